// File: src/assert_macros.svh
// Assertion macros shared by the list engine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Next-cycle implication, disabled during reset.
`define OLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

// File: src/ole_pkg.sv
// Package for the ordered list engine: sizes, codes and cell control struct.
// No dependencies.
package ole_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int LEN_W  = $clog2(DEPTH + 1);
    // compare width wide enough for position, length and length+1
    localparam int CMP_W  = ((LEN_W > 5) ? LEN_W : 5) + 1;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef logic signed [DATA_W-1:0] word_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             do_insert;
        logic             do_delete;
        logic [IDX_W-1:0] pos_idx;
        word_t            value;
        logic [LEN_W-1:0] length;
    } cell_ctrl_t;

endpackage

// File: src/ole_cell.sv
// One list slot: holds a word, shifts with its neighbours, flags a match.
// Depends on ole_pkg.
module ole_cell (
    input  logic               clk,
    input  logic [ole_pkg::IDX_W-1:0] cell_index,
    input  ole_pkg::cell_ctrl_t ctrl,
    input  ole_pkg::word_t     left_word,
    input  ole_pkg::word_t     right_word,
    output ole_pkg::word_t     word,
    output logic               hit
);
    import ole_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.do_insert)
        begin
            if (cell_index == ctrl.pos_idx)
                word_next = ctrl.value;
            else if (cell_index > ctrl.pos_idx)
                word_next = left_word;
        end
        else if (ctrl.do_delete)
        begin
            if (cell_index >= ctrl.pos_idx)
                word_next = right_word;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    // only held words take part in a search
    assign hit  = (word_reg == ctrl.value) &&
                  (LEN_W'(cell_index) < ctrl.length);

endmodule

// File: src/ordered_list_engine_core.sv
// Top level of the ordered list engine: controller and a row of list cells.
// Depends on ole_pkg, ole_cell and assert_macros.svh.
//
//  channel | handshake           | fields                                          | dir
//  --------+---------------------+-------------------------------------------------+----
//  command | in_valid/in_ready   | command, position, value                        | in
//  result  | out_valid/out_ready | status, read_value, found_position, list_length | out
//
// A command is latched into the command registers when accepted; in S_EXEC the
// cells and the result register are then updated together. Every cell compares
// and shifts in parallel, so a command's duration does not depend on list length.
// A new command is taken while a result waits; its update is held until the
// result register is free. Reset empties the list; words read as undefined
// until written, but only held words are ever read or compared.
module ordered_list_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [4:0]  position,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic signed [31:0] read_value,
    output logic [4:0]  found_position,
    output logic [4:0]  list_length
);
    import ole_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // latched command
    cmd_t        cmd_reg;
    logic [4:0]  pos_reg;
    word_t       val_reg;

    logic [LEN_W-1:0] length_reg, length_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic signed [31:0] rd_reg, rd_next;
    logic [4:0]  found_reg, found_next;

    // cell row
    word_t       cell_word [DEPTH];
    logic [DEPTH-1:0] cell_hit;
    cell_ctrl_t  ctrl;

    logic        accept;
    logic        fire;
    logic [CMP_W-1:0] pos_c, len_c;
    logic        pos_nonzero, pos_in_list, pos_insertable, is_full;
    word_t       sel_word;
    logic [IDX_W-1:0] pos_idx;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    // the update commits only when the result register can take it
    assign fire     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign pos_c          = CMP_W'(pos_reg);
    assign len_c          = CMP_W'(length_reg);
    assign pos_nonzero    = (pos_reg != 5'd0);
    assign pos_in_list    = pos_nonzero && (pos_c <= len_c);
    assign pos_insertable = pos_nonzero && (pos_c <= len_c + CMP_W'(1));
    assign is_full        = (len_c == CMP_W'(DEPTH));
    assign pos_idx        = IDX_W'(pos_c - CMP_W'(1));

    always_comb
    begin
        ctrl.do_insert = fire && (cmd_reg == CMD_INSERT) && pos_insertable && !is_full;
        ctrl.do_delete = fire && (cmd_reg == CMD_DELETE) && pos_in_list;
        ctrl.pos_idx   = pos_idx;
        ctrl.value     = val_reg;
        ctrl.length    = length_reg;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            word_t left_w, right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_left
                assign left_w = cell_word[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_right
                assign right_w = cell_word[g+1];
            end

            ole_cell u_cell (
                .clk        (clk),
                .cell_index (IDX_W'(g)),
                .ctrl       (ctrl),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (cell_word[g]),
                .hit        (cell_hit[g])
            );
        end
    endgenerate

    // one-hot select of the addressed word
    always_comb
    begin
        sel_word = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (pos_idx == IDX_W'(k))
                sel_word = sel_word | cell_word[k];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        length_next    = length_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        found_next     = found_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    rd_next        = '0;
                    found_next     = '0;
                    case (cmd_reg)
                        CMD_READ:
                        begin
                            if (pos_in_list)
                                rd_next = 32'(sel_word);
                            else
                                status_next = ST_BADPOS;
                        end
                        CMD_SEARCH:
                        begin
                            // first match wins: scan from the top down
                            status_next = ST_NOTFOUND;
                            for (int k = DEPTH - 1; k >= 0; k--)
                            begin
                                if (cell_hit[k])
                                begin
                                    status_next = ST_OK;
                                    found_next  = 5'(k + 1);
                                end
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (!pos_insertable)
                                status_next = ST_BADPOS;
                            else if (is_full)
                                status_next = ST_FULL;
                            else
                                length_next = length_reg + LEN_W'(1);
                        end
                        default:
                        begin
                            if (pos_in_list)
                                length_next = length_reg - LEN_W'(1);
                            else
                                status_next = ST_BADPOS;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(command);
            pos_reg <= position;
            val_reg <= DATA_W'(value);
        end
        status_reg <= status_next;
        rd_reg     <= rd_next;
        found_reg  <= found_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign read_value     = rd_reg;
    assign found_position = found_reg;
    assign list_length    = 5'(length_reg);

    `OLE_ASSERT_IMP(a_len_bound, clk, rst_n, 1'b1, CMP_W'(length_reg) <= CMP_W'(DEPTH))
    `OLE_ASSERT_NXT(a_accept_exec, clk, rst_n, accept, state_reg == S_EXEC)
    `OLE_ASSERT_IMP(a_full_len, clk, rst_n, out_valid && status == ST_FULL,
                    CMP_W'(list_length) == CMP_W'(DEPTH))
    `OLE_ASSERT_IMP(a_found_ok, clk, rst_n, out_valid && found_position != 5'd0,
                    status == ST_OK)

endmodule
